>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL; they compile to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/ldd_pkg.sv
// Types and constants for the four-channel LED dimmer register block.
package ldd_pkg;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] byte_value;
  } in_t;

  typedef struct packed {
    logic [13:0] led0_compare;
    logic [13:0] led1_compare;
    logic [13:0] led2_compare;
    logic [13:0] led3_compare;
    logic [3:0]  blink_enables;
    logic        asleep;
  } out_t;

  // Bus event codes.
  localparam logic [1:0] EVT_CONTROL = 2'd0;
  localparam logic [1:0] EVT_DATA    = 2'd1;
  localparam logic [1:0] EVT_STOP    = 2'd2;

  // Auto-increment codes.
  localparam logic [2:0] INC_NONE         = 3'd0;
  localparam logic [2:0] INC_ALL          = 3'd4;
  localparam logic [2:0] INC_BRIGHT       = 3'd5;
  localparam logic [2:0] INC_GROUP        = 3'd6;
  localparam logic [2:0] INC_BRIGHT_GROUP = 3'd7;

  // Register indices.
  localparam logic [3:0] REG_MODE1   = 4'd0;
  localparam logic [3:0] REG_MODE2   = 4'd1;
  localparam logic [3:0] REG_PWM0    = 4'd2;
  localparam logic [3:0] REG_PWM1    = 4'd3;
  localparam logic [3:0] REG_PWM2    = 4'd4;
  localparam logic [3:0] REG_PWM3    = 4'd5;
  localparam logic [3:0] REG_GRPPWM  = 4'd6;
  localparam logic [3:0] REG_GRPFREQ = 4'd7;
  localparam logic [3:0] REG_LEDOUT  = 4'd8;

  // LEDOUT channel codes.
  localparam logic [1:0] LED_OFF   = 2'd0;
  localparam logic [1:0] LED_FULL  = 2'd1;
  localparam logic [1:0] LED_PWM   = 2'd2;
  localparam logic [1:0] LED_BLINK = 2'd3;

  localparam logic [7:0]  MODE1_RESET   = 8'b1001_0001;
  localparam int          SLEEP_BIT     = 4;
  localparam int          INVERT_BIT    = 4;
  localparam logic [7:0]  PWM_MAX       = 8'd255;
  localparam logic [13:0] PWM_STEP      = 14'd40;

endpackage

>>> rtl/four_channel_led_dimmer_registers.sv
// Four-channel LED dimmer register file with bus write front end and output decode.
// Throughput: one bus event per cycle; in_ready = !out_valid || out_ready.
// A stop event's result is registered on out_data the cycle after it is accepted.
// Data events write the register file, control events the pointer, when accepted.
// Reset (synchronous, rst_n low) sets MODE1 to 0x91, all other registers, the
// pointer, the increment mode and the blink flags to zero, and empties the output.
`include "assert_macros.svh"

module four_channel_led_dimmer_registers #(
  parameter int FULL_SCALE     = 10200,
  parameter int REGISTER_COUNT = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ldd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ldd_pkg::out_t out_data
);
  import ldd_pkg::*;

  localparam logic [3:0]  REG_LAST     = 4'(REGISTER_COUNT - 1);
  localparam logic [13:0] FULL_CMP     = 14'(FULL_SCALE);

  logic [7:0] regfile_r [REGISTER_COUNT];
  logic [7:0] regfile_nxt [REGISTER_COUNT];
  logic [3:0] ptr_r, ptr_nxt;
  logic [2:0] inc_r, inc_nxt;
  logic       done_r, done_nxt;
  logic [3:0] blink_r, blink_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_t       out_data_r, out_data_nxt;

  logic       accept;
  logic       wr_en;
  logic [7:0] pwm [4];
  logic [13:0] cmp [4];
  logic [3:0]  flags;

  function automatic logic [3:0] step_ptr(input logic [3:0] ptr, input logic [3:0] limit,
                                          input logic [3:0] start);
    logic [4:0] nxt;
    nxt = {1'b0, ptr} + 5'd1;
    if (nxt > {1'b0, limit}) begin
      return start;
    end
    return nxt[3:0];
  endfunction

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Output decode from the register file as it stands when the stop arrives.
  always_comb begin
    logic [13:0] bright;
    logic [1:0]  code;
    pwm[0] = regfile_r[REG_PWM0];
    pwm[1] = regfile_r[REG_PWM1];
    pwm[2] = regfile_r[REG_PWM2];
    pwm[3] = regfile_r[REG_PWM3];
    flags  = '0;
    for (int ch = 0; ch < 4; ch++) begin
      if (regfile_r[REG_MODE2][INVERT_BIT]) begin
        bright = {6'd0, pwm[ch]} * PWM_STEP;
      end else begin
        bright = {6'd0, PWM_MAX - pwm[ch]} * PWM_STEP;
      end
      code = regfile_r[REG_LEDOUT][2*ch +: 2];
      case (code)
        LED_OFF:  cmp[ch] = '0;
        LED_FULL: cmp[ch] = FULL_CMP;
        default:  cmp[ch] = bright;
      endcase
      flags[ch] = (code == LED_BLINK);
    end
  end

  always_comb begin
    ptr_nxt       = ptr_r;
    inc_nxt       = inc_r;
    done_nxt      = done_r;
    blink_nxt     = blink_r;
    wr_en         = 1'b0;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (accept) begin
      unique case (in_data.mode)
        EVT_CONTROL: begin
          inc_nxt  = in_data.byte_value[7:5];
          ptr_nxt  = in_data.byte_value[3:0];
          done_nxt = 1'b0;
        end
        EVT_DATA: begin
          case (inc_r)
            INC_NONE: begin
              wr_en    = !done_r;
              done_nxt = 1'b1;
            end
            INC_ALL: begin
              wr_en   = 1'b1;
              ptr_nxt = step_ptr(ptr_r, REG_LAST, REG_MODE1);
            end
            INC_BRIGHT: begin
              wr_en   = 1'b1;
              ptr_nxt = step_ptr(ptr_r, REG_PWM3, REG_PWM0);
            end
            INC_GROUP: begin
              wr_en   = 1'b1;
              ptr_nxt = step_ptr(ptr_r, REG_GRPFREQ, REG_GRPPWM);
            end
            INC_BRIGHT_GROUP: begin
              wr_en   = 1'b1;
              ptr_nxt = step_ptr(ptr_r, REG_GRPFREQ, REG_PWM0);
            end
            default: ;
          endcase
        end
        EVT_STOP: begin
          out_valid_nxt = 1'b1;
          if (regfile_r[REG_MODE1][SLEEP_BIT]) begin
            out_data_nxt.led0_compare  = '0;
            out_data_nxt.led1_compare  = '0;
            out_data_nxt.led2_compare  = '0;
            out_data_nxt.led3_compare  = '0;
            out_data_nxt.blink_enables = blink_r;
            out_data_nxt.asleep        = 1'b1;
          end else begin
            out_data_nxt.led0_compare  = cmp[0];
            out_data_nxt.led1_compare  = cmp[1];
            out_data_nxt.led2_compare  = cmp[2];
            out_data_nxt.led3_compare  = cmp[3];
            out_data_nxt.blink_enables = flags;
            out_data_nxt.asleep        = 1'b0;
            blink_nxt                  = flags;
          end
        end
        default: ;
      endcase
    end
  end

  // Pointers at or beyond the register count match no entry, so the write is dropped.
  always_comb begin
    for (int i = 0; i < REGISTER_COUNT; i++) begin
      regfile_nxt[i] = regfile_r[i];
      if (wr_en && ptr_r == 4'(i)) begin
        regfile_nxt[i] = in_data.byte_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REGISTER_COUNT; i++) begin
        regfile_r[i] <= (4'(i) == REG_MODE1) ? MODE1_RESET : 8'd0;
      end
      ptr_r       <= '0;
      inc_r       <= INC_NONE;
      done_r      <= 1'b0;
      blink_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < REGISTER_COUNT; i++) begin
        regfile_r[i] <= regfile_nxt[i];
      end
      ptr_r       <= ptr_nxt;
      inc_r       <= inc_nxt;
      done_r      <= done_nxt;
      blink_r     <= blink_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_CLK(a_stop_gives_result, clk, rst_n, accept && in_data.mode == EVT_STOP |=> out_valid_r, "stop transaction produced no result")
  `ASSERT_CLK(a_no_spurious_result, clk, rst_n, accept && in_data.mode != EVT_STOP |=> !out_valid_r, "result appeared without a stop transaction")
  `ASSERT_CLK(a_sleep_zero, clk, rst_n, out_valid_r && out_data_r.asleep |-> out_data_r.led0_compare == '0 && out_data_r.led1_compare == '0 && out_data_r.led2_compare == '0 && out_data_r.led3_compare == '0, "sleeping result carries a non-zero compare")

endmodule
